// ===== hw/rtl/ipipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipipc_pkg
// Shared types, constants and helper functions for the IPv4 header check and
// IP-in-IP classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ipipc_pkg;

  localparam logic [16:0] MAX_DATAGRAM_BYTES = 17'd65536;
  localparam logic [7:0]  HASH_SEED          = 8'(2333 % 256);
  localparam logic [15:0] PAD_FRAME_LEN      = 16'd46;
  localparam logic [7:0]  TUNNEL_PROTOCOL    = 8'd4;
  localparam int          BUCKET_COUNT       = 256;
  localparam int          BUCKET_BITS        = $clog2(BUCKET_COUNT);
  localparam int          ENTRY_BITS         = 32;
  localparam int          CFG_INDEX_BITS     = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOCAL_ADDRESS     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TUNNEL_PEER       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_PREFIX       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_PREFIX_MASK  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_PREFIX      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_PREFIX_MASK = 3'd5;

  typedef enum logic [3:0] {
    ACT_BAD_LENGTH   = 4'd0,
    ACT_BAD_CHECKSUM = 4'd1,
    ACT_FRAG_HELD    = 4'd2,
    ACT_OVERFLOW     = 4'd3,
    ACT_REASSEMBLED  = 4'd4,
    ACT_DECAP        = 4'd5,
    ACT_TO_PEER      = 4'd6,
    ACT_FORWARD_LEFT = 4'd7,
    ACT_IGNORE       = 4'd8
  } action_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic        from_wire;
    logic        mac_dest_is_local;
    logic [15:0] version_ihl_tos;
    logic [15:0] total_length;
    logic [15:0] identification;
    logic [15:0] flags_fragment;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [15:0] header_checksum;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        learn_source;
    logic [7:0]  bucket;
    logic [5:0]  payload_offset;
    logic [15:0] payload_length;
    logic [15:0] reassembled_length;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } out_item_t;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] tunnel_peer_address;
    logic [31:0] left_prefix;
    logic [31:0] left_prefix_mask;
    logic [31:0] right_prefix;
    logic [31:0] right_prefix_mask;
  } cfg_t;

  // one reassembly bucket entry
  typedef struct packed {
    logic [15:0] expected_total;
    logic [15:0] bytes_received;
  } entry_t;

  // bucket write request from the classifier
  typedef struct packed {
    logic                   write;
    logic [BUCKET_BITS-1:0] addr;
    entry_t                 data;
  } entry_upd_t;

  function automatic logic [7:0] fold_bytes(input logic [31:0] v);
    fold_bytes = v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  function automatic logic [7:0] bucket_hash(input in_item_t it);
    bucket_hash = HASH_SEED ^ fold_bytes(it.source_address)
                ^ fold_bytes(it.destination_address)
                ^ it.identification[15:8] ^ it.identification[7:0];
  endfunction

  // ones-complement header checksum over the fixed 20-byte header
  function automatic logic [15:0] header_sum(input in_item_t it, input logic [7:0] ttl);
    logic [19:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s = 20'(it.version_ihl_tos) + 20'(it.total_length) + 20'(it.identification)
      + 20'(it.flags_fragment) + 20'({ttl, it.protocol_number})
      + 20'(it.source_address[31:16]) + 20'(it.source_address[15:0])
      + 20'(it.destination_address[31:16]) + 20'(it.destination_address[15:0]);
    f1 = 17'(s[15:0]) + 17'(s[19:16]);
    f2 = f1[15:0] + 16'(f1[16]);
    header_sum = ~f2;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipipc_ram.sv =====
// ----------------------------------------------------------------------------
// ipipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipipc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipipc_calc.sv =====
// ----------------------------------------------------------------------------
// ipipc_calc
// Header check, classification and bucket update for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module ipipc_calc
  import ipipc_pkg::*;
(
  input  wire in_item_t   item,
  input  wire cfg_t       cfg,
  input  wire entry_t     entry,
  output out_item_t       result,
  output entry_upd_t      upd
);

  logic [5:0]  hlen;
  logic [15:0] plen;
  logic [7:0]  bucket;
  logic [15:0] flen;
  logic        len_ok;
  logic        sum_ok;
  logic        more;
  logic [15:0] off;
  logic        src_left, src_right, dst_left, dst_right;
  logic        to_local;
  logic        is_frag;
  logic        overflow;
  logic [15:0] rec_new;
  logic [15:0] exp_kept;
  logic [15:0] exp_new;
  logic        complete;
  logic [7:0]  nttl;
  action_t     action;

  // field decode
  assign hlen   = {item.version_ihl_tos[11:8], 2'b00};
  assign plen   = item.total_length - 16'(hlen);
  assign bucket = bucket_hash(item);
  assign more   = item.flags_fragment[13];
  assign off    = {item.flags_fragment[12:0], 3'b000};

  // length check with minimum-frame padding allowance
  assign flen = (item.frame_length == PAD_FRAME_LEN && item.total_length < PAD_FRAME_LEN)
              ? item.total_length : item.frame_length;
  assign len_ok = (flen == item.total_length);
  assign sum_ok = (header_sum(item, item.time_to_live) == item.header_checksum);

  // network membership
  assign src_left  = (item.source_address & cfg.left_prefix_mask) == cfg.left_prefix;
  assign src_right = (item.source_address & cfg.right_prefix_mask) == cfg.right_prefix;
  assign dst_left  = (item.destination_address & cfg.left_prefix_mask) == cfg.left_prefix;
  assign dst_right = (item.destination_address & cfg.right_prefix_mask) == cfg.right_prefix;
  assign to_local  = (item.destination_address == cfg.local_address);

  // fragment accounting
  assign is_frag  = (more || off != 16'd0) && item.protocol_number == TUNNEL_PROTOCOL
                  && to_local;
  assign overflow = (17'(plen) + 17'(off)) >= MAX_DATAGRAM_BYTES;
  assign rec_new  = entry.bytes_received + plen;
  assign exp_kept = (entry.expected_total != 16'd0 && off > entry.expected_total)
                  ? 16'd0 : entry.expected_total;
  assign exp_new  = more ? exp_kept : (off + plen);
  assign complete = (rec_new == exp_new);
  assign nttl     = item.time_to_live - 8'd1;

  // action select
  always_comb begin
    if (!len_ok) begin
      action = ACT_BAD_LENGTH;
    end else if (!sum_ok) begin
      action = ACT_BAD_CHECKSUM;
    end else if (is_frag) begin
      if (overflow) begin
        action = ACT_OVERFLOW;
      end else if (complete) begin
        action = ACT_REASSEMBLED;
      end else begin
        action = ACT_FRAG_HELD;
      end
    end else if (item.protocol_number == TUNNEL_PROTOCOL) begin
      action = ACT_DECAP;
    end else if (src_left && dst_right && item.from_wire && item.mac_dest_is_local) begin
      action = ACT_TO_PEER;
    end else if (src_right && dst_left) begin
      action = ACT_FORWARD_LEFT;
    end else begin
      action = ACT_IGNORE;
    end
  end

  // result fields
  always_comb begin
    result                    = '0;
    result.action             = action;
    result.learn_source       = len_ok && sum_ok && item.from_wire
                              && (item.mac_dest_is_local || to_local)
                              && (src_left || item.source_address == cfg.tunnel_peer_address);
    result.bucket             = bucket;
    result.payload_offset     = hlen;
    result.payload_length     = plen;
    result.reassembled_length = (action == ACT_REASSEMBLED) ? exp_new : 16'd0;
    if (action == ACT_TO_PEER || action == ACT_FORWARD_LEFT) begin
      result.new_ttl      = nttl;
      result.new_checksum = header_sum(item, nttl);
    end
  end

  // bucket write back
  always_comb begin
    upd.write = (action == ACT_REASSEMBLED) || (action == ACT_FRAG_HELD);
    upd.addr  = bucket;
    if (action == ACT_REASSEMBLED) begin
      upd.data = '0;
    end else begin
      upd.data.expected_total = exp_new;
      upd.data.bytes_received = rec_new;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipip_header_classify_reassemble.sv =====
// ----------------------------------------------------------------------------
// ipip_header_classify_reassemble
// IPv4 header length and checksum check, IP-in-IP classification with
// per-bucket fragment byte counting, TTL decrement and checksum rewrite.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in        in_valid/in_stall   in_item (in_item_t)
//  out       out_valid/out_stall out_item (out_item_t)
//  cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
//  one item per cycle while the output is not stalled; an accepted item enters
//  the compute stage (bucket RAM read at acceptance), is classified and written
//  back, and its result is registered; a result register and the compute
//  stage hold one item each, so one more item is accepted while a result waits.
//  synchronous reset clears control state and all 256 bucket valid flags at
//  once; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module ipip_header_classify_reassemble
  import ipipc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_item_t                  in_item,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_item,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data
);

  cfg_t                    cfg;
  logic                    s1_valid;
  in_item_t                s1_item;
  logic                    s1_fwd;
  entry_t                  s1_fwd_data;
  logic                    s1_entry_valid;
  logic [BUCKET_COUNT-1:0] entry_valid;
  logic                    in_accept;
  logic                    s1_advance;
  logic [BUCKET_BITS-1:0]  in_bucket;
  logic [ENTRY_BITS-1:0]   ram_rdata;
  entry_t                  entry;
  out_item_t               result;
  entry_upd_t              upd;
  logic                    ram_we;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;
  assign in_bucket  = bucket_hash(in_item);
  assign ram_we     = s1_advance && upd.write;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_address       <= '0;
      cfg.tunnel_peer_address <= '0;
      cfg.left_prefix         <= '0;
      cfg.left_prefix_mask    <= 32'hFFFF_FF00;
      cfg.right_prefix        <= '0;
      cfg.right_prefix_mask   <= 32'hFFFF_FF00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCAL_ADDRESS:     cfg.local_address       <= cfg_data;
        REG_TUNNEL_PEER:       cfg.tunnel_peer_address <= cfg_data;
        REG_LEFT_PREFIX:       cfg.left_prefix         <= cfg_data;
        REG_LEFT_PREFIX_MASK:  cfg.left_prefix_mask    <= cfg_data;
        REG_RIGHT_PREFIX:      cfg.right_prefix        <= cfg_data;
        REG_RIGHT_PREFIX_MASK: cfg.right_prefix_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // bucket store
  ipipc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (BUCKET_COUNT)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd.addr),
    .wdata (upd.data),
    .re    (in_accept),
    .raddr (in_bucket),
    .rdata (ram_rdata)
  );

  // per-bucket valid flags, an unwritten bucket reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[upd.addr] <= 1'b1;
    end
  end

  // compute stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // compute stage payload, with bypass of a same-cycle bucket write
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item        <= in_item;
      s1_entry_valid <= entry_valid[in_bucket];
      s1_fwd         <= ram_we && (upd.addr == in_bucket);
      s1_fwd_data    <= upd.data;
    end
  end

  assign entry = s1_fwd ? s1_fwd_data : (s1_entry_valid ? entry_t'(ram_rdata) : '0);

  ipipc_calc u_calc (
    .item   (s1_item),
    .cfg    (cfg),
    .entry  (entry),
    .result (result),
    .upd    (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_item <= result;
    end
  end

  // bucket writes only happen as an item leaves the compute stage
  assert property (@(posedge clk) disable iff (rst) ram_we |-> s1_valid && s1_advance)
    else $error("bucket write without an advancing item");

  // input is held off only while the compute stage is occupied and blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked item");

  // an accepted item reaches the compute stage next cycle
  assert property (@(posedge clk) disable iff (rst) in_accept |=> s1_valid)
    else $error("accepted item lost");

  // a reassembled result always writes back a cleared bucket entry
  assert property (@(posedge clk) disable iff (rst)
    s1_advance && result.action == ACT_REASSEMBLED |-> upd.write && upd.data == '0)
    else $error("reassembly did not clear its bucket");

endmodule

`default_nettype wire

// ===== dv/ipip_header_classify_reassemble_test.sv =====
// ----------------------------------------------------------------------------
// ipip_header_classify_reassemble_test
// Self-checking bench for the IPv4 header check and IP-in-IP classifier.
// Headers are fed in random bursts, the output side stalls on its own pattern,
// and each result is compared with a local prediction of action, hash, lengths,
// TTL and checksum, which tracks the per-bucket fragment byte counts. Several
// register settings are used, each one written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ipip_header_classify_reassemble_test
  import ipipc_pkg::*;
();

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  in_item_t       in_item;
  logic           out_valid;
  logic           out_stall;
  out_item_t      out_item;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [31:0]    cfg_data;

  ipip_header_classify_reassemble DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and bucket store
  cfg_t        mdl_cfg;
  logic [15:0] mdl_rcvd [256];
  logic [15:0] mdl_total [256];

  in_item_t  header_queue [$];
  out_item_t expected_results [$];
  int        error_count;
  int        burst_left;
  int        gap_left;
  logic      hold_sender;
  logic      in_taken;
  int        stall_phase;
  int        stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ones-complement sum of the fixed header with a chosen ttl
  function automatic logic [15:0] fixed_sum(input in_item_t h, input logic [7:0] ttl);
    logic [31:0] s;
    s = 32'(h.version_ihl_tos) + 32'(h.total_length) + 32'(h.identification)
      + 32'(h.flags_fragment) + 32'({ttl, h.protocol_number})
      + 32'(h.source_address[31:16]) + 32'(h.source_address[15:0])
      + 32'(h.destination_address[31:16]) + 32'(h.destination_address[15:0]);
    s = (s & 32'hffff) + (s >> 16);
    s = (s & 32'hffff) + (s >> 16);
    return ~s[15:0];
  endfunction

  function automatic logic [7:0] xor_bytes(input logic [31:0] v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  // classify one header and update the bucket store
  function automatic out_item_t classify_header(input in_item_t h);
    out_item_t r;
    logic [15:0] flen;
    logic [5:0]  hlen;
    logic [15:0] plen;
    logic [7:0]  b;
    logic        sl, sr, dl, dr, more;
    logic [31:0] off;
    action_t     act;
    r = '0;
    hlen = {h.version_ihl_tos[11:8], 2'b00};
    plen = h.total_length - 16'(hlen);
    b = 8'(2333 % 256) ^ xor_bytes(h.source_address) ^ xor_bytes(h.destination_address)
      ^ h.identification[15:8] ^ h.identification[7:0];
    sl = (h.source_address & mdl_cfg.left_prefix_mask) == mdl_cfg.left_prefix;
    sr = (h.source_address & mdl_cfg.right_prefix_mask) == mdl_cfg.right_prefix;
    dl = (h.destination_address & mdl_cfg.left_prefix_mask) == mdl_cfg.left_prefix;
    dr = (h.destination_address & mdl_cfg.right_prefix_mask) == mdl_cfg.right_prefix;
    flen = h.frame_length;
    if (flen == 16'd46 && h.total_length < 16'd46) flen = h.total_length;
    if (flen != h.total_length) begin
      act = ACT_BAD_LENGTH;
    end else if (fixed_sum(h, h.time_to_live) != h.header_checksum) begin
      act = ACT_BAD_CHECKSUM;
    end else begin
      more = h.flags_fragment[13];
      off = 32'(h.flags_fragment[12:0]) << 3;
      if (h.from_wire && (h.mac_dest_is_local || h.destination_address == mdl_cfg.local_address)
          && (sl || h.source_address == mdl_cfg.tunnel_peer_address))
        r.learn_source = 1'b1;
      if ((more || off != 0) && h.protocol_number == 8'd4
          && h.destination_address == mdl_cfg.local_address) begin
        if (32'(plen) + off >= 32'd65536) begin
          act = ACT_OVERFLOW;
        end else begin
          mdl_rcvd[b] = mdl_rcvd[b] + plen;
          if (mdl_total[b] != 0 && off > 32'(mdl_total[b])) mdl_total[b] = '0;
          if (!more) mdl_total[b] = 16'(off) + plen;
          if (mdl_rcvd[b] == mdl_total[b]) begin
            act = ACT_REASSEMBLED;
            r.reassembled_length = mdl_total[b];
            mdl_rcvd[b] = '0;
            mdl_total[b] = '0;
          end else begin
            act = ACT_FRAG_HELD;
          end
        end
      end else if (h.protocol_number == 8'd4) begin
        act = ACT_DECAP;
      end else if (sl && dr && h.from_wire && h.mac_dest_is_local) begin
        act = ACT_TO_PEER;
      end else if (sr && dl) begin
        act = ACT_FORWARD_LEFT;
      end else begin
        act = ACT_IGNORE;
      end
      if (act == ACT_TO_PEER || act == ACT_FORWARD_LEFT) begin
        r.new_ttl = h.time_to_live - 8'd1;
        r.new_checksum = fixed_sum(h, r.new_ttl);
      end
    end
    r.action = act;
    r.bucket = b;
    r.payload_offset = hlen;
    r.payload_length = plen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: bursts and gaps at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (header_queue.size() > 0 && !hold_sender) begin
          in_item <= header_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(20, 0);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      // receiver stall pattern
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 == 0) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ($urandom_range(1, 0) == 0);
        default: out_stall <= (stall_phase % 7) < 3;
      endcase
    end
  end

  // prediction on acceptance, check on result
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) expected_results.push_back(classify_header(in_item));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item.action), 32'hffffffff);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.action !== exp_r.action)
            report_mismatch("action", 32'(out_item.action), 32'(exp_r.action));
          if (out_item.learn_source !== exp_r.learn_source)
            report_mismatch("learn_source", 32'(out_item.learn_source),
                            32'(exp_r.learn_source));
          if (out_item.bucket !== exp_r.bucket)
            report_mismatch("bucket", 32'(out_item.bucket), 32'(exp_r.bucket));
          if (out_item.payload_offset !== exp_r.payload_offset)
            report_mismatch("payload_offset", 32'(out_item.payload_offset),
                            32'(exp_r.payload_offset));
          if (out_item.payload_length !== exp_r.payload_length)
            report_mismatch("payload_length", 32'(out_item.payload_length),
                            32'(exp_r.payload_length));
          if (out_item.reassembled_length !== exp_r.reassembled_length)
            report_mismatch("reassembled_length", 32'(out_item.reassembled_length),
                            32'(exp_r.reassembled_length));
          if (out_item.new_ttl !== exp_r.new_ttl)
            report_mismatch("new_ttl", 32'(out_item.new_ttl), 32'(exp_r.new_ttl));
          if (out_item.new_checksum !== exp_r.new_checksum)
            report_mismatch("new_checksum", 32'(out_item.new_checksum),
                            32'(exp_r.new_checksum));
        end
      end
    end
  end

  // register write while idle, at the falling edge
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOCAL_ADDRESS:     mdl_cfg.local_address = val;
      REG_TUNNEL_PEER:       mdl_cfg.tunnel_peer_address = val;
      REG_LEFT_PREFIX:       mdl_cfg.left_prefix = val;
      REG_LEFT_PREFIX_MASK:  mdl_cfg.left_prefix_mask = val;
      REG_RIGHT_PREFIX:      mdl_cfg.right_prefix = val;
      default:               mdl_cfg.right_prefix_mask = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (header_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // address drawn from the tunnel's own networks most of the time
  function automatic logic [31:0] pick_address();
    case ($urandom_range(5, 0))
      0: return mdl_cfg.left_prefix | ($urandom & ~mdl_cfg.left_prefix_mask);
      1: return mdl_cfg.right_prefix | ($urandom & ~mdl_cfg.right_prefix_mask);
      2: return mdl_cfg.local_address;
      3: return mdl_cfg.tunnel_peer_address;
      default: return $urandom;
    endcase
  endfunction

  // build a header with given shape, then fix lengths and checksum
  function automatic in_item_t make_header(input logic [15:0] tl, input logic [15:0] ff,
                                           input logic [7:0] proto,
                                           input logic [31:0] sa, input logic [31:0] da,
                                           input logic [15:0] id);
    in_item_t h;
    h.from_wire = 1'($urandom_range(1, 0));
    h.mac_dest_is_local = 1'($urandom_range(1, 0));
    h.version_ihl_tos = {4'h4, 4'($urandom_range(15, 5)), 8'($urandom)};
    h.total_length = tl;
    h.frame_length = (tl < 46 && $urandom_range(1, 0)) ? 16'd46 : tl;
    h.identification = id;
    h.flags_fragment = ff;
    h.time_to_live = 8'($urandom);
    h.protocol_number = proto;
    h.source_address = sa;
    h.destination_address = da;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    return h;
  endfunction

  // a datagram cut into fragments sent in order, shuffled now and then
  task automatic queue_fragments();
    int          nfrag;
    logic [15:0] id;
    logic [31:0] sa;
    logic [31:0] off;
    logic [15:0] plen;
    logic [5:0]  hl;
    in_item_t    h;
    in_item_t    parts [$];
    nfrag = $urandom_range(4, 1);
    id = 16'($urandom);
    sa = pick_address();
    off = 0;
    for (int k = 0; k < nfrag; k++) begin
      plen = 16'($urandom_range(40, 1) * 8);
      h = make_header(16'd0, 16'd0, TUNNEL_PROTOCOL, sa, mdl_cfg.local_address, id);
      hl = {h.version_ihl_tos[11:8], 2'b00};
      h.total_length = plen + 16'(hl);
      h.frame_length = h.total_length;
      h.flags_fragment = {2'b00, (k != nfrag - 1), 13'(off >> 3)};
      h.header_checksum = fixed_sum(h, h.time_to_live);
      parts.push_back(h);
      off += plen;
    end
    if ($urandom_range(4, 0) == 0) parts.shuffle();
    foreach (parts[k]) header_queue.push_back(parts[k]);
  endtask

  task automatic queue_random(input int count);
    in_item_t h;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9, 0))
        0, 1, 2: queue_fragments();
        3: begin
          h = '0;
          h = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
          header_queue.push_back(h);
        end
        4: begin
          h = make_header(16'($urandom), {$urandom_range(7, 0) == 0 ? 3'($urandom) : 3'b000,
              13'($urandom)}, ($urandom_range(1, 0)) ? TUNNEL_PROTOCOL : 8'($urandom),
              pick_address(), pick_address(), 16'($urandom));
          if ($urandom_range(3, 0) == 0) h.header_checksum ^= 16'(1 << $urandom_range(15, 0));
          if ($urandom_range(5, 0) == 0) h.frame_length = 16'($urandom);
          header_queue.push_back(h);
        end
        default: begin
          h = make_header(16'($urandom_range(1500, 20)), 16'h4000,
              ($urandom_range(4, 0) == 0) ? TUNNEL_PROTOCOL : 8'($urandom_range(255, 5)),
              pick_address(), pick_address(), 16'($urandom));
          header_queue.push_back(h);
        end
      endcase
    end
  endtask

  task automatic queue_directed();
    in_item_t h;
    logic [31:0] l;
    logic [31:0] r;
    l = mdl_cfg.left_prefix | 32'h5;
    r = mdl_cfg.right_prefix | 32'h9;
    // to peer, forward left, ignore, decapsulate
    h = make_header(16'd60, 16'h0, 8'd17, l, r, 16'h1234);
    h.from_wire = 1'b1; h.mac_dest_is_local = 1'b1;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    h.from_wire = 1'b0;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    header_queue.push_back(make_header(16'd100, 16'h0, 8'd6, r, l, 16'h0));
    h = make_header(16'd100, 16'h0, 8'd6, r, l, 16'hffff);
    h.time_to_live = 8'd0;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    header_queue.push_back(make_header(16'd80, 16'h0, 8'd1, 32'hffffffff, 32'h0, 16'h0));
    header_queue.push_back(make_header(16'd200, 16'h0, TUNNEL_PROTOCOL, 32'h0,
                                       32'hffffffff, 16'h0));
    // padded short frame and a plain short-length mismatch
    h = make_header(16'd28, 16'h0, 8'd17, l, r, 16'h7);
    h.frame_length = 16'd46;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    h.frame_length = 16'd47;
    header_queue.push_back(h);
    h.frame_length = 16'd0;
    h.total_length = 16'hffff;
    header_queue.push_back(h);
    // bad checksum
    h = make_header(16'd64, 16'h0, 8'd17, l, r, 16'h9);
    h.header_checksum = ~h.header_checksum;
    header_queue.push_back(h);
    // overflow fragment at the largest offset
    header_queue.push_back(make_header(16'hffff, 16'h3fff, TUNNEL_PROTOCOL, l,
                                       mdl_cfg.local_address, 16'h55));
    // empty datagram: fragment at offset zero with no payload and more-fragments set
    h = make_header(16'd20, 16'h2000, TUNNEL_PROTOCOL, l, mdl_cfg.local_address, 16'h66);
    h.version_ihl_tos[11:8] = 4'd5;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    // late fragment beyond the known length, then a first fragment with more to come
    h = make_header(16'd36, 16'h0001, TUNNEL_PROTOCOL, l, mdl_cfg.local_address, 16'h77);
    h.version_ihl_tos[11:8] = 4'd5;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    h.flags_fragment = 16'h0010;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    h.flags_fragment = 16'h2000;
    h.header_checksum = fixed_sum(h, h.time_to_live);
    header_queue.push_back(h);
    queue_fragments();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    in_taken = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LOCAL_ADDRESS;
    cfg_data = '0;
    error_count = 0;
    burst_left = 0;
    gap_left = 0;
    hold_sender = 1'b0;
    stall_phase = 0;
    stall_mode = 0;
    mdl_cfg = '{32'h0, 32'h0, 32'h0, 32'hffffff00, 32'h0, 32'hffffff00};
    foreach (mdl_rcvd[k]) begin
      mdl_rcvd[k] = '0;
      mdl_total[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // reset settings first
    queue_directed();
    queue_random(60);
    wait_idle();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_register(REG_LOCAL_ADDRESS, 32'h0a000001);
          write_register(REG_TUNNEL_PEER, 32'hc0a80101);
          write_register(REG_LEFT_PREFIX, 32'h0a000100);
          write_register(REG_LEFT_PREFIX_MASK, 32'hffffff00);
          write_register(REG_RIGHT_PREFIX, 32'hac100000);
          write_register(REG_RIGHT_PREFIX_MASK, 32'hffff0000);
        end
        1: begin
          write_register(REG_LOCAL_ADDRESS, 32'hffffffff);
          write_register(REG_TUNNEL_PEER, 32'hffffffff);
          write_register(REG_LEFT_PREFIX, 32'h0);
          write_register(REG_LEFT_PREFIX_MASK, 32'h0);
          write_register(REG_RIGHT_PREFIX, 32'hffffffff);
          write_register(REG_RIGHT_PREFIX_MASK, 32'hffffffff);
        end
        2: begin
          // prefix with bits outside its mask never matches
          write_register(REG_LEFT_PREFIX, 32'h0a0001ff);
          write_register(REG_LEFT_PREFIX_MASK, 32'hffffff00);
          write_register(REG_RIGHT_PREFIX, 32'h0);
          write_register(REG_RIGHT_PREFIX_MASK, 32'h0);
          write_register(REG_LOCAL_ADDRESS, 32'h0);
        end
        default: begin
          write_register(REG_LOCAL_ADDRESS, $urandom);
          write_register(REG_TUNNEL_PEER, $urandom);
          mdl_cfg.left_prefix_mask = ~((32'h1 << $urandom_range(31, 0)) - 1);
          write_register(REG_LEFT_PREFIX_MASK, mdl_cfg.left_prefix_mask);
          write_register(REG_LEFT_PREFIX, $urandom & mdl_cfg.left_prefix_mask);
          mdl_cfg.right_prefix_mask = ~((32'h1 << $urandom_range(31, 0)) - 1);
          write_register(REG_RIGHT_PREFIX_MASK, mdl_cfg.right_prefix_mask);
          write_register(REG_RIGHT_PREFIX, $urandom & mdl_cfg.right_prefix_mask);
        end
      endcase
      queue_random(210);
      if (phase == 2) begin
        // sender holds off until the block has drained
        while (header_queue.size() > 100) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== ipip_header_classify_reassemble.f =====
hw/rtl/ipipc_pkg.sv
hw/rtl/ipipc_ram.sv
hw/rtl/ipipc_calc.sv
hw/rtl/ipip_header_classify_reassemble.sv
dv/ipip_header_classify_reassemble_test.sv
